### rtl/cdr_pkg.sv
package cdr_pkg;

  localparam logic [1:0] OP_PUSH_FRONT = 2'd0;
  localparam logic [1:0] OP_PUSH_BACK  = 2'd1;
  localparam logic [1:0] OP_POP_FRONT  = 2'd2;
  localparam logic [1:0] OP_POP_BACK   = 2'd3;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;
  localparam logic [1:0] ST_MODE  = 2'd3;

  localparam logic [1:0] MODE_FREE   = 2'd0;
  localparam logic [1:0] MODE_IN_RES = 2'd1;
  localparam logic [1:0] MODE_OUT_RES = 2'd2;

  localparam int WordW = 32;

  typedef struct packed {
    logic load;
    logic exec;
  } cmd_t;

endpackage

### rtl/cdr_ctrl.sv
module cdr_ctrl
  import cdr_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  output logic out_valid,
  input  logic out_stall,
  output cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_OUT  = 3'b100
  } state_t;

  state_t state, state_next;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_EXEC;
      end
      S_EXEC: begin
        state_next = S_OUT;
      end
      S_OUT: begin
        if (!out_stall) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall  = (state != S_IDLE);
  assign out_valid = (state == S_OUT);
  assign cmd.load  = (state == S_IDLE) && in_valid;
  assign cmd.exec  = (state == S_EXEC);

  a_accept_then_exec: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> cmd.exec)
    else $error("accepted item not executed next cycle");

  a_exec_then_out: assert property (@(posedge clk) disable iff (rst)
    cmd.exec |=> out_valid)
    else $error("result not presented after execute");

  a_no_accept_while_busy: assert property (@(posedge clk) disable iff (rst)
    (out_valid || cmd.exec) |-> in_stall)
    else $error("input open while an item is in flight");

endmodule

### rtl/cdr_dpath.sv
module cdr_dpath
  import cdr_pkg::*;
#(
  parameter int DEPTH = 8
) (
  input  logic                    clk,
  input  logic                    rst,
  input  cmd_t                    cmd,
  input  logic [1:0]              op,
  input  logic signed [WordW-1:0] push_value,
  input  logic                    cfg_we,
  input  logic [1:0]              cfg_data,
  output logic [1:0]              status,
  output logic signed [WordW-1:0] pop_value,
  output logic                    now_full,
  output logic                    now_empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [AW-1:0] LastPos = AW'(DEPTH - 1);

  logic signed [WordW-1:0] mem [DEPTH];
  logic signed [WordW-1:0] rd_data;
  logic signed [WordW-1:0] val_q;
  logic [1:0]    op_q;
  logic [1:0]    mode;
  logic [AW-1:0] head, head_next;
  logic [AW-1:0] tail, tail_next;
  logic          empty_q, empty_next;
  logic [1:0]    status_q, st_c;
  logic          pop_ok, pop_ok_c;
  logic          wr_en;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [AW-1:0] tail_inc, head_inc, head_dec, tail_dec;
  logic          full_c, refused_mode, is_push;

  assign tail_inc = (tail == LastPos) ? '0 : tail + AW'(1);
  assign head_inc = (head == LastPos) ? '0 : head + AW'(1);
  assign head_dec = (head == '0) ? LastPos : head - AW'(1);
  assign tail_dec = (tail == '0) ? LastPos : tail - AW'(1);
  assign full_c   = !empty_q && (tail_inc == head);

  assign refused_mode = (op_q == OP_PUSH_FRONT && mode == MODE_IN_RES) ||
                        (op_q == OP_POP_BACK && mode == MODE_OUT_RES);
  assign is_push = (op_q == OP_PUSH_FRONT) || (op_q == OP_PUSH_BACK);

  always_comb begin
    head_next  = head;
    tail_next  = tail;
    empty_next = empty_q;
    st_c       = ST_DONE;
    pop_ok_c   = 1'b0;
    wr_en      = 1'b0;
    wr_addr    = '0;
    rd_addr    = head;
    if (refused_mode) begin
      st_c = ST_MODE;
    end else if (is_push) begin
      if (full_c) begin
        st_c = ST_FULL;
      end else if (empty_q) begin
        // first word always lands at position zero
        head_next  = '0;
        tail_next  = '0;
        empty_next = 1'b0;
        wr_en      = 1'b1;
      end else if (op_q == OP_PUSH_FRONT) begin
        head_next = head_dec;
        wr_en     = 1'b1;
        wr_addr   = head_dec;
      end else begin
        tail_next = tail_inc;
        wr_en     = 1'b1;
        wr_addr   = tail_inc;
      end
    end else begin
      if (empty_q) begin
        st_c = ST_EMPTY;
      end else begin
        pop_ok_c = 1'b1;
        rd_addr  = (op_q == OP_POP_FRONT) ? head : tail;
        if (head == tail) begin
          head_next  = '0;
          tail_next  = '0;
          empty_next = 1'b1;
        end else if (op_q == OP_POP_FRONT) begin
          head_next = head_inc;
        end else begin
          tail_next = tail_dec;
        end
      end
    end
  end

  // latch the accepted item
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q  <= op;
      val_q <= push_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head    <= '0;
      tail    <= '0;
      empty_q <= 1'b1;
      mode    <= MODE_FREE;
    end else begin
      if (cmd.exec) begin
        head    <= head_next;
        tail    <= tail_next;
        empty_q <= empty_next;
      end
      if (cfg_we) mode <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      status_q <= st_c;
      pop_ok   <= pop_ok_c;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && wr_en) mem[wr_addr] <= val_q;
    if (cmd.exec) rd_data <= mem[rd_addr];
  end

  assign status    = status_q;
  assign pop_value = pop_ok ? rd_data : '0;
  assign now_empty = empty_q;
  assign now_full  = full_c;

  a_empty_at_origin: assert property (@(posedge clk) disable iff (rst)
    empty_q |-> (head == '0 && tail == '0))
    else $error("empty deque with indices off origin");

  a_refused_holds: assert property (@(posedge clk) disable iff (rst)
    (cmd.exec && st_c != ST_DONE) |=>
      ($stable(head) && $stable(tail) && $stable(empty_q)))
    else $error("refused operation changed state");

  a_push_fills: assert property (@(posedge clk) disable iff (rst)
    (cmd.exec && is_push && st_c == ST_DONE) |=> !empty_q)
    else $error("deque empty after a done push");

endmodule

### rtl/circular_deque_restricted_top.sv
// Double-ended queue of DEPTH 32-bit words in a circular store.
// Input channel (in_valid / in_stall): op selects push front, push back,
// pop front or pop back; push_value is the word stored by a push. An item
// is taken when in_valid is high and in_stall is low.
// Output channel (out_valid / out_stall): one result per item with status,
// pop_value (zero unless a pop succeeded), now_full and now_empty.
// Configuration channel (cfg_valid / cfg_ready / cfg_data) writes the
// restriction mode: 0 free, 1 no front push, 2 no back pop, 3 acts as 0.
// Write it only while no item is in flight.
// Timing: an item is accepted, executed in the next cycle (one memory
// access and the index update), and its result is shown the cycle after.
// No new item is taken until the result of the last has been delivered.
// While out_stall is high the result holds and no new item is taken.
// Reset empties the deque and clears the mode; store contents are left.
module circular_deque_restricted_top
  import cdr_pkg::*;
#(
  parameter int DEPTH = 8
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [1:0]              op,
  input  logic signed [WordW-1:0] push_value,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [1:0]              status,
  output logic signed [WordW-1:0] pop_value,
  output logic                    now_full,
  output logic                    now_empty,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [1:0]              cfg_data
);

  cmd_t cmd;

  assign cfg_ready = 1'b1;

  cdr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  cdr_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .op         (op),
    .push_value (push_value),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_data   (cfg_data),
    .status     (status),
    .pop_value  (pop_value),
    .now_full   (now_full),
    .now_empty  (now_empty)
  );

endmodule
